// File: hw/rtl/wf23_pkg.sv
// Shared types and constants of the Winograd F(2,3) input transform.
package wf23_pkg;

  localparam int unsigned WF_QUEUE_DEPTH = 2;

  localparam int unsigned ROWS_PER_TILE = 4;
  localparam int unsigned COLS_PER_TILE = 4;

  typedef logic signed [7:0] sample_t;
  typedef logic signed [8:0] partial_t;
  typedef logic signed [9:0] coeff_t;
  typedef logic [1:0]        idx_t;

  localparam idx_t LAST_ROW = 2'd3;
  localparam idx_t LAST_COL = 2'd3;

  // Reduced rows of one tile: rows 0..2 as kept, row 3 straight from the row transform.
  typedef struct packed {
    partial_t [ROWS_PER_TILE-1:0][COLS_PER_TILE-1:0] p;
  } tile_t;

  typedef struct packed {
    logic  valid;
    tile_t tile;
  } q_push_t;

  typedef struct packed {
    logic  full;
    logic  empty;
    tile_t head;
  } q_stat_t;

  typedef struct packed {
    idx_t rows_seen;
  } front_stat_t;

endpackage

// File: hw/rtl/wf23_if.sv
// Stream interfaces for tile rows in and transformed columns out.
interface wf23_row_if;
  import wf23_pkg::*;

  logic    valid;
  logic    ready;
  sample_t row_sample_0;
  sample_t row_sample_1;
  sample_t row_sample_2;
  sample_t row_sample_3;

  modport source (output valid, output row_sample_0, output row_sample_1,
                  output row_sample_2, output row_sample_3, input ready);
  modport sink   (input valid, input row_sample_0, input row_sample_1,
                  input row_sample_2, input row_sample_3, output ready);
endinterface

interface wf23_col_if;
  import wf23_pkg::*;

  logic   valid;
  logic   ready;
  idx_t   column_index;
  coeff_t coeff_0;
  coeff_t coeff_1;
  coeff_t coeff_2;
  coeff_t coeff_3;
  logic   tile_last;

  modport source (output valid, output column_index, output coeff_0, output coeff_1,
                  output coeff_2, output coeff_3, output tile_last, input ready);
  modport sink   (input valid, input column_index, input coeff_0, input coeff_1,
                  input coeff_2, input coeff_3, input tile_last, output ready);
endinterface

// File: hw/rtl/winograd_f23_input_transform.sv
// Top level of the Winograd F(2,3) input transform of 4x4 signed byte tiles.
//
//   Channel | Dir | Handshake      | Carries
//   --------+-----+----------------+-------------------------------------------
//   row_i   | in  | valid / ready  | one tile row, row_sample_0..3 (int8)
//   col_o   | out | valid / ready  | column_index, coeff_0..3 (10 bit), tile_last
//
// Rows are taken one per cycle; only a fourth row waits, while the queue is full.
// Rows one to three of a tile only update the kept reduced rows; the fourth row
// pushes the whole tile into a short queue, and the column side then delivers the
// four columns in order from its output register. The tile is first written into
// the queue, then its first column is loaded into the output register and shown.
// Sustained throughput, with the output ready, is one row and one result per cycle;
// the column side's single output register sets that, four results per four rows.
// Reset clears the row count, the queue pointers and fill count, the column count
// and the output valid; stored partials are overwritten before they are read.
// A stalled output only holds back the fourth row of a tile, and only once the
// queue is full.
module winograd_f23_input_transform #(
  parameter int unsigned QueueDepth = wf23_pkg::WF_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wf23_row_if.sink   row_i,
  wf23_col_if.source col_o
);
  import wf23_pkg::*;

  q_push_t     q_push;
  q_stat_t     q_stat;
  front_stat_t f_stat;
  logic        q_pop;

  // Row side: row transform and tile assembly.
  wf23_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .row_i    (row_i),
    .q_stat_i (q_stat),
    .q_push_o (q_push),
    .stat_o   (f_stat)
  );

  // Decouples row arrival from column delivery.
  wf23_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .pop_i  (q_pop),
    .stat_o (q_stat)
  );

  // Column side: column transform and output register.
  wf23_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .pop_o    (q_pop),
    .col_o    (col_o)
  );

  // The row side never pushes a tile into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push.valid |-> !q_stat.full)
    else $error("tile pushed into full queue");

  // The column side never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // A fourth-row transfer restarts the row count of the next tile.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_i.valid && row_i.ready && f_stat.rows_seen == LAST_ROW)
      |=> (f_stat.rows_seen == '0))
    else $error("row count did not wrap after fourth row");

  // The last mark sits on the fourth column and nowhere else.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_o.valid |-> (col_o.tile_last == (col_o.column_index == LAST_COL)))
    else $error("tile_last does not match column index");

endmodule

// File: hw/rtl/wf23_front.sv
// Row side: takes tile rows, applies the row transform and assembles tiles.
module wf23_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  wf23_row_if.sink              row_i,
  input  wf23_pkg::q_stat_t     q_stat_i,
  output wf23_pkg::q_push_t     q_push_o,
  output wf23_pkg::front_stat_t stat_o
);
  import wf23_pkg::*;

  idx_t     rows_q, rows_d;
  partial_t [ROWS_PER_TILE-2:0][COLS_PER_TILE-1:0] keep_q;
  partial_t [COLS_PER_TILE-1:0] red;
  logic     xfer;

  // Row transform [x0-x2, x1+x2, x2-x1, x1-x3].
  always_comb begin
    red[0] = partial_t'(row_i.row_sample_0) - partial_t'(row_i.row_sample_2);
    red[1] = partial_t'(row_i.row_sample_1) + partial_t'(row_i.row_sample_2);
    red[2] = partial_t'(row_i.row_sample_2) - partial_t'(row_i.row_sample_1);
    red[3] = partial_t'(row_i.row_sample_1) - partial_t'(row_i.row_sample_3);
  end

  // The last row of a tile needs a free queue slot; the others never wait.
  assign row_i.ready = (rows_q != LAST_ROW) || !q_stat_i.full;
  assign xfer        = row_i.valid && row_i.ready;
  assign rows_d      = xfer ? rows_q + idx_t'(1) : rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= '0;
    end else begin
      rows_q <= rows_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < ROWS_PER_TILE - 1; r++) begin
      if (xfer && rows_q == idx_t'(r)) begin
        keep_q[r] <= red;
      end
    end
  end

  always_comb begin
    q_push_o.valid     = xfer && (rows_q == LAST_ROW);
    q_push_o.tile.p[0] = keep_q[0];
    q_push_o.tile.p[1] = keep_q[1];
    q_push_o.tile.p[2] = keep_q[2];
    q_push_o.tile.p[3] = red;
  end

  assign stat_o.rows_seen = rows_q;

endmodule

// File: hw/rtl/wf23_queue.sv
// Short queue of assembled tiles between the row side and the column side.
module wf23_queue #(
  parameter int unsigned Depth = wf23_pkg::WF_QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wf23_pkg::q_push_t push_i,
  input  logic              pop_i,
  output wf23_pkg::q_stat_t stat_o
);
  import wf23_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tile_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] ptr);
    logic [PtrW-1:0] res;
    if (ptr == PtrW'(Depth - 1)) begin
      res = '0;
    end else begin
      res = ptr + PtrW'(1);
    end
    return res;
  endfunction

  assign do_push = push_i.valid && (cnt_q != CntW'(Depth));
  assign do_pop  = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wrap_inc(wr_q);
      end
      if (do_pop) begin
        rd_q <= wrap_inc(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.tile;
    end
  end

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.head  = mem_q[rd_q];

endmodule

// File: hw/rtl/wf23_back.sv
// Column side: runs the column transform on the head tile, one column per result.
module wf23_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wf23_pkg::q_stat_t q_stat_i,
  output logic              pop_o,
  wf23_col_if.source        col_o
);
  import wf23_pkg::*;

  idx_t     k_q;
  logic     valid_q;
  logic     load;
  partial_t c0, c1, c2, c3;
  idx_t     col_q;
  coeff_t   t0_q, t1_q, t2_q, t3_q;

  assign load  = !valid_q || col_o.ready;
  assign pop_o = load && !q_stat_i.empty && (k_q == LAST_COL);

  always_comb begin
    c0 = q_stat_i.head.p[0][k_q];
    c1 = q_stat_i.head.p[1][k_q];
    c2 = q_stat_i.head.p[2][k_q];
    c3 = q_stat_i.head.p[3][k_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      k_q     <= '0;
    end else if (load) begin
      valid_q <= !q_stat_i.empty;
      if (!q_stat_i.empty) begin
        k_q <= k_q + idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !q_stat_i.empty) begin
      col_q <= k_q;
      t0_q  <= coeff_t'(c0) - coeff_t'(c2);
      t1_q  <= coeff_t'(c1) + coeff_t'(c2);
      t2_q  <= coeff_t'(c2) - coeff_t'(c1);
      t3_q  <= coeff_t'(c1) - coeff_t'(c3);
    end
  end

  assign col_o.valid        = valid_q;
  assign col_o.column_index = col_q;
  assign col_o.coeff_0      = t0_q;
  assign col_o.coeff_1      = t1_q;
  assign col_o.coeff_2      = t2_q;
  assign col_o.coeff_3      = t3_q;
  assign col_o.tile_last    = (col_q == LAST_COL);

endmodule
